>>> rtl/cmaf_pkg.sv
// ----------------------------------------------------------------------------
// Command APDU access filter package
// Shared types, instruction codes, verdict codes and the forbidden file id
// lookup that the filter uses.
// ----------------------------------------------------------------------------
package cmaf_pkg;

	// Verdict codes given on the last byte of an APDU.
	typedef enum logic [2:0] {
		VERDICT_OK          = 3'd0,
		VERDICT_MALFORMED   = 3'd1,
		VERDICT_SELECT_AID  = 3'd2,
		VERDICT_MANAGE_CHAN = 3'd3,
		VERDICT_BAD_CLA     = 3'd4,
		VERDICT_FORBIDDEN   = 3'd5
	} verdict_t;

	// Instruction and parameter codes of interest.
	localparam logic [7:0] INS_SELECT     = 8'hA4;
	localparam logic [7:0] INS_ACTIVATE   = 8'h44;
	localparam logic [7:0] INS_DEACTIVATE = 8'h04;
	localparam logic [7:0] INS_MANAGE_CH  = 8'h70;
	localparam logic [7:0] P1_BY_AID      = 8'h04;
	localparam logic [7:0] P1_BY_FILE_ID  = 8'h00;
	localparam logic [7:0] P1_PATH_MF     = 8'h08;
	localparam logic [7:0] P1_PATH_CUR    = 8'h09;

	// Accepted CLA high nibbles on a nonzero logical channel.
	localparam logic [3:0] CLA_HI_ISO     = 4'h0;
	localparam logic [3:0] CLA_HI_PROP8   = 4'h8;
	localparam logic [3:0] CLA_HI_PROP9   = 4'h9;
	localparam logic [3:0] CLA_HI_PROPA   = 4'hA;

	// Header byte positions inside the APDU.
	localparam logic [8:0] POS_CLA        = 9'd0;
	localparam logic [8:0] POS_INS        = 9'd1;
	localparam logic [8:0] POS_P1         = 9'd2;
	localparam logic [8:0] POS_LC         = 9'd4;
	localparam logic [8:0] POS_DATA       = 9'd5;

	// True when a two-byte file id is one of the protected ids.
	function automatic logic is_forbidden(input logic [15:0] id);
		logic hit;
		hit = 1'b0;
		case (id) inside
			16'h7F10, 16'h7F20, 16'h7F21, 16'h7F22, 16'h7F23, 16'h7F24,
			16'h7F25, 16'h7F26, 16'h7F27, 16'h7F28, 16'h7F29, 16'h7F2A,
			16'h7F2B, 16'h7F2C, 16'h7F2D, 16'h7F2E, 16'h7F2F, 16'h7F80,
			16'h7F90, 16'h7F31, 16'h7F50, 16'h5015: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

>>> rtl/cmaf_if.sv
// ----------------------------------------------------------------------------
// Command APDU access filter channels
// Valid/ready channels for APDU bytes, verdicts and the channel register.
// ----------------------------------------------------------------------------

// One APDU byte per item.
interface cmaf_apdu_if;
	logic       valid;
	logic       ready;
	logic [7:0] apdu_byte;
	logic       end_of_apdu;

	modport source (output valid, output apdu_byte, output end_of_apdu, input ready);
	modport sink   (input valid, input apdu_byte, input end_of_apdu, output ready);
endinterface

// One verdict per completed APDU.
interface cmaf_result_if;
	import cmaf_pkg::*;
	logic       valid;
	logic       ready;
	verdict_t   verdict;
	logic [8:0] apdu_length;

	modport source (output valid, output verdict, output apdu_length, input ready);
	modport sink   (input valid, input verdict, input apdu_length, output ready);
endinterface

// Write channel of the logical channel register.
interface cmaf_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] logical_channel;

	modport source (output valid, output logical_channel, input ready);
	modport sink   (input valid, input logical_channel, output ready);
endinterface

>>> rtl/command_apdu_access_filter_top.sv
// ----------------------------------------------------------------------------
// Command APDU access filter
// Checks a command APDU byte by byte and gives one verdict on its last byte.
// ----------------------------------------------------------------------------
//
// Channel  Role  Item contents
// -------  ----  -----------------------------------------
// apdu     sink  apdu_byte, end_of_apdu
// result   src   verdict, apdu_length (one per final byte)
// cfg      sink  logical_channel (always ready)
//
// Each accepted byte passes an input register, then the header capture, id
// lookup and verdict logic into the result register. A byte can be accepted
// every cycle; the only stall is a final byte waiting while the result
// register holds an untaken verdict.
// Reset clears the APDU state, the channel register and both valid flags.
//
module command_apdu_access_filter_top
	import cmaf_pkg::*;
#(
	parameter int MAX_APDU_BYTES = 261
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cmaf_apdu_if.sink            apdu,
	cmaf_result_if.source        result,
	cmaf_cfg_if.sink             cfg
);

	localparam logic [8:0] MaxCount = 9'(MAX_APDU_BYTES);

	// Configuration register.
	logic [4:0] logical_channel_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoa_s1;

	// APDU state.
	logic [8:0] byte_count_q;
	logic [7:0] class_byte_q;
	logic [7:0] instruction_byte_q;
	logic [7:0] param1_byte_q;
	logic [7:0] length_byte_q;
	logic [7:0] pending_id_high_q;
	logic       forbidden_seen_q;
	logic       overlong_q;

	// Next state after taking the staged byte.
	logic [8:0] count_n;
	logic [7:0] class_n;
	logic [7:0] ins_n;
	logic [7:0] p1_n;
	logic [7:0] lc_n;
	logic [7:0] id_high_n;
	logic       forbidden_n;
	logic       overlong_n;

	// Verdict logic.
	logic [8:0] data_len;
	logic [8:0] lc_plus_one;
	logic [3:0] cla_hi;
	logic       file_ins;
	verdict_t   verdict_n;

	// Handshake.
	logic       out_free;
	logic       s1_fire;

	assign out_free     = !result.valid || result.ready;
	assign s1_fire      = valid_s1 && (!eoa_s1 || out_free);
	assign apdu.ready   = !valid_s1 || s1_fire;
	assign cfg.ready    = 1'b1;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logical_channel_q <= '0;
		end else if (cfg.valid) begin
			logical_channel_q <= cfg.logical_channel;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (apdu.ready) begin
			valid_s1 <= apdu.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (apdu.valid && apdu.ready) begin
			byte_s1 <= apdu.apdu_byte;
			eoa_s1  <= apdu.end_of_apdu;
		end
	end

	// Take the staged byte into the header and id tracking state.
	always_comb begin
		count_n     = byte_count_q;
		class_n     = class_byte_q;
		ins_n       = instruction_byte_q;
		p1_n        = param1_byte_q;
		lc_n        = length_byte_q;
		id_high_n   = pending_id_high_q;
		forbidden_n = forbidden_seen_q;
		overlong_n  = overlong_q;
		if (byte_count_q >= MaxCount) begin
			overlong_n = 1'b1;
		end else begin
			count_n = byte_count_q + 9'd1;
			if (byte_count_q == POS_CLA) begin
				class_n = byte_s1;
			end else if (byte_count_q == POS_INS) begin
				ins_n = byte_s1;
			end else if (byte_count_q == POS_P1) begin
				p1_n = byte_s1;
			end else if (byte_count_q == POS_LC) begin
				lc_n = byte_s1;
			end else if (byte_count_q >= POS_DATA) begin
				if (byte_count_q[0]) begin
					id_high_n = byte_s1;
				end else if (is_forbidden({pending_id_high_q, byte_s1})) begin
					forbidden_n = 1'b1;
				end
			end
		end
	end

	// Verdict on the state that includes the final byte.
	assign data_len    = count_n - POS_DATA;
	assign lc_plus_one = {1'b0, lc_n} + 9'd1;
	assign cla_hi      = class_n[7:4];
	assign file_ins    = (ins_n == INS_SELECT) || (ins_n == INS_DEACTIVATE)
		|| (ins_n == INS_ACTIVATE);

	always_comb begin
		verdict_n = VERDICT_OK;
		if (overlong_n || count_n < 9'd4) begin
			verdict_n = VERDICT_MALFORMED;
		end else if (count_n > 9'd6 && data_len != {1'b0, lc_n} && data_len != lc_plus_one) begin
			verdict_n = VERDICT_MALFORMED;
		end else if (ins_n == INS_SELECT && p1_n == P1_BY_AID) begin
			verdict_n = VERDICT_SELECT_AID;
		end else if (ins_n == INS_MANAGE_CH) begin
			verdict_n = VERDICT_MANAGE_CHAN;
		end else if (logical_channel_q != 5'd0 && !(cla_hi inside
				{CLA_HI_ISO, CLA_HI_PROP8, CLA_HI_PROP9, CLA_HI_PROPA})) begin
			verdict_n = VERDICT_BAD_CLA;
		end else if (file_ins && count_n > 9'd5) begin
			if (p1_n == P1_BY_FILE_ID) begin
				if (data_len != 9'd2) begin
					verdict_n = VERDICT_MALFORMED;
				end else if (forbidden_n) begin
					verdict_n = VERDICT_FORBIDDEN;
				end
			end else if (p1_n == P1_PATH_MF || p1_n == P1_PATH_CUR) begin
				if (data_len[0]) begin
					verdict_n = VERDICT_MALFORMED;
				end else if (forbidden_n) begin
					verdict_n = VERDICT_FORBIDDEN;
				end
			end
		end
	end

	// APDU state update; the final byte clears it for the next APDU.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q       <= '0;
			class_byte_q       <= '0;
			instruction_byte_q <= '0;
			param1_byte_q      <= '0;
			length_byte_q      <= '0;
			pending_id_high_q  <= '0;
			forbidden_seen_q   <= 1'b0;
			overlong_q         <= 1'b0;
		end else if (s1_fire) begin
			if (eoa_s1) begin
				byte_count_q       <= '0;
				class_byte_q       <= '0;
				instruction_byte_q <= '0;
				param1_byte_q      <= '0;
				length_byte_q      <= '0;
				pending_id_high_q  <= '0;
				forbidden_seen_q   <= 1'b0;
				overlong_q         <= 1'b0;
			end else begin
				byte_count_q       <= count_n;
				class_byte_q       <= class_n;
				instruction_byte_q <= ins_n;
				param1_byte_q      <= p1_n;
				length_byte_q      <= lc_n;
				pending_id_high_q  <= id_high_n;
				forbidden_seen_q   <= forbidden_n;
				overlong_q         <= overlong_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (out_free) begin
			result.valid <= s1_fire && eoa_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && eoa_s1) begin
			result.verdict     <= verdict_n;
			result.apdu_length <= count_n;
		end
	end

endmodule
